// ----- rtl/core/udps_pkg.sv -----
// ----------------------------------------------------------------------------
// udps_pkg
// Shared widths, reset values and types for the up/down pot sequencer.
// ----------------------------------------------------------------------------
package udps_pkg;

  localparam int unsigned POS_BITS_DEF = 7;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned CPU_W  = 8;
  localparam int unsigned HALF_W = 8;
  localparam int unsigned DSU_W  = 8;
  localparam int unsigned US_W   = 20;
  localparam int unsigned ZP_W   = 7;
  localparam int unsigned MAXP_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_US = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC_HALF_US   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_SETUP_US  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_WAIT_US = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PULSES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION  = 3'd5;

  // register reset values
  localparam logic [CPU_W-1:0]  RST_CLOCKS_PER_US = 8'd1;
  localparam logic [HALF_W-1:0] RST_INC_HALF_US   = 8'd1;
  localparam logic [DSU_W-1:0]  RST_DIR_SETUP_US  = 8'd3;
  localparam logic [US_W-1:0]   RST_STORE_WAIT_US = 20'd20000;
  localparam logic [ZP_W-1:0]   RST_ZERO_PULSES   = 7'd99;
  localparam logic [MAXP_W-1:0] RST_MAX_POSITION  = 7'd99;

  typedef struct packed {
    logic            tick;
    logic            load;
    logic [US_W-1:0] load_us;
  } tmr_ctrl_t;

  typedef struct packed {
    logic cs_n;
    logic up_dn;
    logic inc_n;
    logic busy_res;
    logic rejected;
    logic done_res;
  } res_t;

endpackage

// ----- rtl/core/udps_chan_if.sv -----
// ----------------------------------------------------------------------------
// udps_in_if / udps_out_if
// Valid/ready channels for command words and pin-level result words.
// ----------------------------------------------------------------------------
interface udps_in_if
  import udps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [POS_W-1:0] position;

  modport source (output valid, output cmd, output position, input ready);
  modport sink   (input valid, input cmd, input position, output ready);
endinterface

interface udps_out_if;
  logic valid;
  logic ready;
  logic cs_n;
  logic up_dn;
  logic inc_n;
  logic busy_res;
  logic rejected;
  logic done_res;

  modport source (output valid, output cs_n, output up_dn, output inc_n,
                  output busy_res, output rejected, output done_res, input ready);
  modport sink   (input valid, input cs_n, input up_dn, input inc_n,
                  input busy_res, input rejected, input done_res, output ready);
endinterface

// ----- rtl/core/updown_pot_position_sequencer.sv -----
// ----------------------------------------------------------------------------
// updown_pot_position_sequencer
// Three-wire select, up/down and increment control of a digital potentiometer.
// ----------------------------------------------------------------------------
// Each input word is one tick of the timing base and produces exactly one
// result word with the pin levels after that tick. One word is taken every
// clock while in_ch.ready is high; the result sits in a single output
// register, and ready drops only while it is full and not taken. All
// pulse and wait timing is counted in accepted words, not in clock cycles.
// Commands that arrive while a sequence runs are flagged and ignored.
module updown_pot_position_sequencer
  import udps_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  udps_in_if.sink               in_ch,
  udps_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CPU_W-1:0]  clocks_per_us_r;
  logic [HALF_W-1:0] inc_half_us_r;
  logic [DSU_W-1:0]  dir_setup_us_r;
  logic [US_W-1:0]   store_wait_us_r;
  logic [ZP_W-1:0]   zero_pulses_r;
  logic [MAXP_W-1:0] max_position_r;

  logic              out_valid_r, out_valid_nxt;
  res_t              res_r;
  res_t              res;
  tmr_ctrl_t         tmr_ctrl;
  logic              elapsed;
  logic              accept;
  logic [CPU_W-1:0]  per;
  logic [HALF_W-1:0] half_us;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // zero in either timing register acts as one
  assign per     = (clocks_per_us_r == '0) ? CPU_W'(1) : clocks_per_us_r;
  assign half_us = (inc_half_us_r == '0) ? HALF_W'(1) : inc_half_us_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clocks_per_us_r <= RST_CLOCKS_PER_US;
      inc_half_us_r   <= RST_INC_HALF_US;
      dir_setup_us_r  <= RST_DIR_SETUP_US;
      store_wait_us_r <= RST_STORE_WAIT_US;
      zero_pulses_r   <= RST_ZERO_PULSES;
      max_position_r  <= RST_MAX_POSITION;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CLOCKS_PER_US: clocks_per_us_r <= cfg_wdata[CPU_W-1:0];
        REG_INC_HALF_US:   inc_half_us_r   <= cfg_wdata[HALF_W-1:0];
        REG_DIR_SETUP_US:  dir_setup_us_r  <= cfg_wdata[DSU_W-1:0];
        REG_STORE_WAIT_US: store_wait_us_r <= cfg_wdata[US_W-1:0];
        REG_ZERO_PULSES:   zero_pulses_r   <= cfg_wdata[ZP_W-1:0];
        REG_MAX_POSITION:  max_position_r  <= cfg_wdata[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  udps_timer u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (tmr_ctrl),
    .per     (per),
    .elapsed (elapsed)
  );

  udps_fsm #(
    .POS_BITS (POS_BITS)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .cmd           (in_ch.cmd),
    .position      (in_ch.position),
    .half_us       (half_us),
    .dir_setup_us  (dir_setup_us_r),
    .store_wait_us (store_wait_us_r),
    .zero_pulses   (zero_pulses_r),
    .max_position  (max_position_r),
    .elapsed       (elapsed),
    .tmr_ctrl      (tmr_ctrl),
    .res           (res)
  );

  // hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.cs_n     = res_r.cs_n;
  assign out_ch.up_dn    = res_r.up_dn;
  assign out_ch.inc_n    = res_r.inc_n;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.rejected = res_r.rejected;
  assign out_ch.done_res = res_r.done_res;

endmodule

// ----- rtl/core/udps_timer.sv -----
// ----------------------------------------------------------------------------
// udps_timer
// Microsecond wait counter: sub-microsecond prescaler plus microsecond count.
// ----------------------------------------------------------------------------
module udps_timer
  import udps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_ctrl_t        ctrl,
  input  logic [CPU_W-1:0] per,
  output logic             elapsed
);

  logic [CPU_W-1:0] sub_r, sub_nxt;
  logic [US_W-1:0]  us_r, us_nxt;
  logic [CPU_W-1:0] sub_inc;
  logic             roll;
  logic [US_W-1:0]  us_dec;

  always_comb begin
    sub_inc = sub_r + CPU_W'(1);
    roll    = (sub_inc >= per);
    us_dec  = roll ? (us_r - US_W'(1)) : us_r;
    // a zero count has already run out
    elapsed = (us_r == '0) || (us_dec == '0);
  end

  always_comb begin
    sub_nxt = sub_r;
    us_nxt  = us_r;
    if (ctrl.load) begin
      sub_nxt = '0;
      us_nxt  = ctrl.load_us;
    end else if (ctrl.tick && (us_r != '0)) begin
      sub_nxt = roll ? '0 : sub_inc;
      us_nxt  = us_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
      us_r  <= '0;
    end else begin
      sub_r <= sub_nxt;
      us_r  <= us_nxt;
    end
  end

endmodule

// ----- rtl/core/udps_fsm.sv -----
// ----------------------------------------------------------------------------
// udps_fsm
// Pin sequencer: zeroing pulses, up pulses, end hold and optional store.
// ----------------------------------------------------------------------------
module udps_fsm
  import udps_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [HALF_W-1:0] half_us,
  input  logic [DSU_W-1:0]  dir_setup_us,
  input  logic [US_W-1:0]   store_wait_us,
  input  logic [ZP_W-1:0]   zero_pulses,
  input  logic [MAXP_W-1:0] max_position,
  input  logic              elapsed,
  output tmr_ctrl_t         tmr_ctrl,
  output res_t              res
);

  localparam int unsigned CntW = (POS_BITS > ZP_W) ? POS_BITS : ZP_W;
  localparam logic [CntW-1:0] PosMax = CntW'((1 << POS_BITS) - 1);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_DN_SETUP   = 4'd1;
  localparam logic [3:0] PH_DN_HIGH    = 4'd2;
  localparam logic [3:0] PH_DN_LOW     = 4'd3;
  localparam logic [3:0] PH_UP_SETUP   = 4'd4;
  localparam logic [3:0] PH_UP_HIGH    = 4'd5;
  localparam logic [3:0] PH_UP_LOW     = 4'd6;
  localparam logic [3:0] PH_END_HOLD   = 4'd7;
  localparam logic [3:0] PH_STORE_INC  = 4'd8;
  localparam logic [3:0] PH_STORE_WAIT = 4'd9;

  logic [3:0]          phase_r, phase_nxt;
  logic [CntW-1:0]     pulse_r, pulse_nxt;
  logic [POS_BITS-1:0] target_r, target_nxt;
  logic                store_r, store_nxt;
  logic                cs_r, cs_nxt;
  logic                dir_r, dir_nxt;
  logic                inc_r, inc_nxt;

  logic            busy;
  logic            is_cmd;
  logic            done;
  logic [CntW-1:0] lim;
  logic [CntW-1:0] req;
  logic [CntW-1:0] tgt;
  logic [CntW-1:0] pulse_dec;
  logic [US_W-1:0] half_w;

  assign busy      = (phase_r != PH_IDLE);
  assign is_cmd    = (cmd == CMD_SET) || (cmd == CMD_STORE);
  assign half_w    = US_W'(half_us);
  assign pulse_dec = pulse_r - CntW'(1);

  // clamp request to the smaller of max_position and the position range
  always_comb begin
    lim = (CntW'(max_position) > PosMax) ? PosMax : CntW'(max_position);
    req = CntW'(position);
    tgt = (req > lim) ? lim : req;
  end

  always_comb begin
    phase_nxt  = phase_r;
    pulse_nxt  = pulse_r;
    target_nxt = target_r;
    store_nxt  = store_r;
    cs_nxt     = cs_r;
    dir_nxt    = dir_r;
    inc_nxt    = inc_r;
    done       = 1'b0;
    tmr_ctrl.tick    = accept && busy;
    tmr_ctrl.load    = 1'b0;
    tmr_ctrl.load_us = '0;

    if (accept) begin
      if (!busy) begin
        if (is_cmd) begin
          target_nxt = tgt[POS_BITS-1:0];
          store_nxt  = (cmd == CMD_STORE);
          cs_nxt     = 1'b0;
          dir_nxt    = 1'b0;
          phase_nxt  = PH_DN_SETUP;
          tmr_ctrl.load    = 1'b1;
          tmr_ctrl.load_us = US_W'(dir_setup_us);
        end
      end else if (elapsed) begin
        case (phase_r)
          PH_DN_SETUP: begin
            pulse_nxt     = CntW'(zero_pulses);
            tmr_ctrl.load = 1'b1;
            if (zero_pulses != '0) begin
              inc_nxt          = 1'b1;
              phase_nxt        = PH_DN_HIGH;
              tmr_ctrl.load_us = half_w;
            end else begin
              dir_nxt          = 1'b1;
              phase_nxt        = PH_UP_SETUP;
              tmr_ctrl.load_us = US_W'(dir_setup_us);
            end
          end
          PH_DN_HIGH: begin
            inc_nxt          = 1'b0;
            phase_nxt        = PH_DN_LOW;
            tmr_ctrl.load    = 1'b1;
            tmr_ctrl.load_us = half_w;
          end
          PH_DN_LOW: begin
            pulse_nxt     = pulse_dec;
            tmr_ctrl.load = 1'b1;
            if (pulse_dec != '0) begin
              inc_nxt          = 1'b1;
              phase_nxt        = PH_DN_HIGH;
              tmr_ctrl.load_us = half_w;
            end else begin
              dir_nxt          = 1'b1;
              phase_nxt        = PH_UP_SETUP;
              tmr_ctrl.load_us = US_W'(dir_setup_us);
            end
          end
          PH_UP_SETUP: begin
            pulse_nxt     = CntW'(target_r);
            tmr_ctrl.load = 1'b1;
            if (target_r != '0) begin
              inc_nxt          = 1'b1;
              phase_nxt        = PH_UP_HIGH;
              tmr_ctrl.load_us = half_w;
            end else begin
              inc_nxt          = 1'b0;
              phase_nxt        = PH_END_HOLD;
              tmr_ctrl.load_us = US_W'(1);
            end
          end
          PH_UP_HIGH: begin
            inc_nxt          = 1'b0;
            phase_nxt        = PH_UP_LOW;
            tmr_ctrl.load    = 1'b1;
            tmr_ctrl.load_us = half_w;
          end
          PH_UP_LOW: begin
            pulse_nxt     = pulse_dec;
            tmr_ctrl.load = 1'b1;
            if (pulse_dec != '0) begin
              inc_nxt          = 1'b1;
              phase_nxt        = PH_UP_HIGH;
              tmr_ctrl.load_us = half_w;
            end else begin
              inc_nxt          = 1'b0;
              phase_nxt        = PH_END_HOLD;
              tmr_ctrl.load_us = US_W'(1);
            end
          end
          PH_END_HOLD: begin
            if (store_r) begin
              // raise increment with select low, then the select edge stores
              inc_nxt          = 1'b1;
              phase_nxt        = PH_STORE_INC;
              tmr_ctrl.load    = 1'b1;
              tmr_ctrl.load_us = US_W'(1);
            end else begin
              cs_nxt    = 1'b1;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
          PH_STORE_INC: begin
            cs_nxt           = 1'b1;
            phase_nxt        = PH_STORE_WAIT;
            tmr_ctrl.load    = 1'b1;
            tmr_ctrl.load_us = store_wait_us;
          end
          default: begin
            store_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.cs_n     = cs_nxt;
    res.up_dn    = dir_nxt;
    res.inc_n    = inc_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.rejected = busy && is_cmd;
    res.done_res = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pulse_r  <= '0;
      target_r <= '0;
      store_r  <= 1'b0;
      cs_r     <= 1'b1;
      dir_r    <= 1'b0;
      inc_r    <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      pulse_r  <= pulse_nxt;
      target_r <= target_nxt;
      store_r  <= store_nxt;
      cs_r     <= cs_nxt;
      dir_r    <= dir_nxt;
      inc_r    <= inc_nxt;
    end
  end

endmodule

// ----- rtl/core/udps_chk.sv -----
// ----------------------------------------------------------------------------
// udps_chk
// Port-level checks on the result channel of the pot sequencer.
// ----------------------------------------------------------------------------
module udps_chk (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic cs_n,
  input logic up_dn,
  input logic inc_n,
  input logic busy_res,
  input logic rejected,
  input logic done_res
);

  // a finished sequence leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done word still shows busy");

  // select is released whenever a sequence finishes
  a_done_desel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> cs_n)
    else $error("done word with device still selected");

  // idle never leaves the device selected
  a_idle_desel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> cs_n)
    else $error("idle word with device selected");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cs_n) && $stable(up_dn)
      && $stable(inc_n) && $stable(busy_res) && $stable(rejected)
      && $stable(done_res))
    else $error("stalled result word changed");

endmodule

bind updown_pot_position_sequencer udps_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cs_n      (out_ch.cs_n),
  .up_dn     (out_ch.up_dn),
  .inc_n     (out_ch.inc_n),
  .busy_res  (out_ch.busy_res),
  .rejected  (out_ch.rejected),
  .done_res  (out_ch.done_res)
);

// ----- test/tb_updown_pot_position_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_updown_pot_position_sequencer
// Self-checking bench for the up/down pot position sequencer. A pin-level
// tracker follows every accepted command word and queues the select,
// direction and increment levels it should produce; each result word is
// checked against the oldest queued entry. Register settings go from all
// ones to all zero, then to small random settings so that full set
// and store sequences finish often.
// ----------------------------------------------------------------------------
module tb_updown_pot_position_sequencer;
  import udps_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_RSVD   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned LAST_PHASE = 8;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_DN_SETUP, SQ_DN_HIGH, SQ_DN_LOW, SQ_UP_SETUP,
    SQ_UP_HIGH, SQ_UP_LOW, SQ_END_HOLD, SQ_STORE_INC, SQ_STORE_WAIT
  } seq_phase_t;

  class pot_pin_tracker;
    logic [CPU_W-1:0]  clk_per_us;
    logic [HALF_W-1:0] half_us;
    logic [DSU_W-1:0]  setup_us;
    logic [US_W-1:0]   store_us;
    logic [ZP_W-1:0]   zero_cnt;
    logic [MAXP_W-1:0] max_pos;

    seq_phase_t        ph;
    logic [7:0]        sub_cnt;
    logic [US_W-1:0]   us_left;
    logic [POS_W-1:0]  pulses;
    logic [POS_W-1:0]  target;
    logic              store_pend, cs, dir, inc;

    res_t              pin_levels_q[$];
    int unsigned       n_err;
    int unsigned       n_seen;

    function new();
      clk_per_us = RST_CLOCKS_PER_US;
      half_us    = RST_INC_HALF_US;
      setup_us   = RST_DIR_SETUP_US;
      store_us   = RST_STORE_WAIT_US;
      zero_cnt   = RST_ZERO_PULSES;
      max_pos    = RST_MAX_POSITION;
      ph         = SQ_IDLE;
      sub_cnt    = '0;
      us_left    = '0;
      pulses     = '0;
      target     = '0;
      store_pend = 1'b0;
      cs         = 1'b1;
      dir        = 1'b0;
      inc        = 1'b1;
      n_err      = 0;
      n_seen     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CLOCKS_PER_US: clk_per_us = data[CPU_W-1:0];
        REG_INC_HALF_US:   half_us    = data[HALF_W-1:0];
        REG_DIR_SETUP_US:  setup_us   = data[DSU_W-1:0];
        REG_STORE_WAIT_US: store_us   = data[US_W-1:0];
        REG_ZERO_PULSES:   zero_cnt   = data[ZP_W-1:0];
        REG_MAX_POSITION:  max_pos    = data[MAXP_W-1:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return ph != SQ_IDLE;
    endfunction

    function int unsigned pending();
      return pin_levels_q.size();
    endfunction

    function void load_wait(seq_phase_t nxt, logic [US_W-1:0] us);
      ph      = nxt;
      us_left = us;
      sub_cnt = '0;
    endfunction

    function logic [US_W-1:0] half_wait();
      return (half_us == 0) ? US_W'(1) : US_W'(half_us);
    endfunction

    // zero clocks per microsecond counts as one
    function bit tick_wait();
      logic [7:0] per;
      per = (clk_per_us == 0) ? 8'd1 : clk_per_us;
      if (us_left == 0) return 1'b1;
      sub_cnt = sub_cnt + 8'd1;
      if (sub_cnt >= per) begin
        sub_cnt = '0;
        us_left = us_left - US_W'(1);
      end
      return us_left == 0;
    endfunction

    function void apply_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos);
      res_t        lv;
      logic        is_cmd;
      int unsigned lim;
      lv = '0;
      is_cmd = (cmd == CMD_SET) || (cmd == CMD_STORE);
      if (ph == SQ_IDLE) begin
        if (is_cmd) begin
          lim = (1 << POS_BITS_DEF) - 1;
          if (lim > max_pos) lim = max_pos;
          target     = (pos > lim) ? lim[POS_W-1:0] : pos;
          store_pend = (cmd == CMD_STORE);
          cs         = 1'b0;
          dir        = 1'b0;
          load_wait(SQ_DN_SETUP, US_W'(setup_us));
        end
      end else begin
        lv.rejected = is_cmd;
        if (tick_wait()) begin
          case (ph)
            SQ_DN_SETUP: begin
              pulses = zero_cnt;
              if (pulses > 0) begin
                inc = 1'b1;
                load_wait(SQ_DN_HIGH, half_wait());
              end else begin
                dir = 1'b1;
                load_wait(SQ_UP_SETUP, US_W'(setup_us));
              end
            end
            SQ_DN_HIGH: begin
              inc = 1'b0;
              load_wait(SQ_DN_LOW, half_wait());
            end
            SQ_DN_LOW: begin
              pulses = pulses - POS_W'(1);
              if (pulses > 0) begin
                inc = 1'b1;
                load_wait(SQ_DN_HIGH, half_wait());
              end else begin
                dir = 1'b1;
                load_wait(SQ_UP_SETUP, US_W'(setup_us));
              end
            end
            SQ_UP_SETUP: begin
              pulses = target;
              if (pulses > 0) begin
                inc = 1'b1;
                load_wait(SQ_UP_HIGH, half_wait());
              end else begin
                inc = 1'b0;
                load_wait(SQ_END_HOLD, US_W'(1));
              end
            end
            SQ_UP_HIGH: begin
              inc = 1'b0;
              load_wait(SQ_UP_LOW, half_wait());
            end
            SQ_UP_LOW: begin
              pulses = pulses - POS_W'(1);
              if (pulses > 0) begin
                inc = 1'b1;
                load_wait(SQ_UP_HIGH, half_wait());
              end else begin
                inc = 1'b0;
                load_wait(SQ_END_HOLD, US_W'(1));
              end
            end
            SQ_END_HOLD: begin
              // store: raise increment with select still low, then lift select
              if (store_pend) begin
                inc = 1'b1;
                load_wait(SQ_STORE_INC, US_W'(1));
              end else begin
                cs = 1'b1;
                ph = SQ_IDLE;
                lv.done_res = 1'b1;
              end
            end
            SQ_STORE_INC: begin
              cs = 1'b1;
              load_wait(SQ_STORE_WAIT, store_us);
            end
            default: begin
              store_pend  = 1'b0;
              ph          = SQ_IDLE;
              lv.done_res = 1'b1;
            end
          endcase
        end
      end
      lv.cs_n     = cs;
      lv.up_dn    = dir;
      lv.inc_n    = inc;
      lv.busy_res = (ph != SQ_IDLE);
      pin_levels_q.push_back(lv);
    endfunction

    function void compare_pins(res_t got);
      res_t want;
      n_seen++;
      if (pin_levels_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("word %0d: result with nothing expected, got %b", n_seen, got);
        return;
      end
      want = pin_levels_q.pop_front();
      if (got.cs_n !== want.cs_n || got.up_dn !== want.up_dn ||
          got.inc_n !== want.inc_n || got.busy_res !== want.busy_res ||
          got.rejected !== want.rejected || got.done_res !== want.done_res) begin
        n_err++;
        if (n_err <= 10)
          $display("word %0d: cs_n/up_dn/inc_n/busy/rej/done want %b%b%b%b%b%b got %b%b%b%b%b%b",
                   n_seen, want.cs_n, want.up_dn, want.inc_n, want.busy_res,
                   want.rejected, want.done_res, got.cs_n, got.up_dn, got.inc_n,
                   got.busy_res, got.rejected, got.done_res);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  udps_in_if  in_if();
  udps_out_if out_if();

  pot_pin_tracker board;
  bit             idling;
  bit             long_hold_req;

  updown_pot_position_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left  = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : pin_monitor
    res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.cs_n     = out_if.cs_n;
      got.up_dn    = out_if.up_dn;
      got.inc_n    = out_if.inc_n;
      got.busy_res = out_if.busy_res;
      got.rejected = out_if.rejected;
      got.done_res = out_if.done_res;
      board.compare_pins(got);
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos);
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.position <= pos;
    do @(posedge clk); while (!in_if.ready);
    board.apply_word(cmd, pos);
  endtask

  task automatic src_gap(int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [CPU_W-1:0] cpu, logic [HALF_W-1:0] half,
                              logic [DSU_W-1:0] setup, logic [US_W-1:0] store,
                              logic [ZP_W-1:0] zp, logic [MAXP_W-1:0] maxp);
    write_reg(REG_CLOCKS_PER_US, CFG_DATA_W'(cpu));
    write_reg(REG_INC_HALF_US, CFG_DATA_W'(half));
    write_reg(REG_DIR_SETUP_US, CFG_DATA_W'(setup));
    write_reg(REG_STORE_WAIT_US, CFG_DATA_W'(store));
    write_reg(REG_ZERO_PULSES, CFG_DATA_W'(zp));
    write_reg(REG_MAX_POSITION, CFG_DATA_W'(maxp));
    // unused index must be ignored
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
    cfg_we <= 1'b0;
  endtask

  // mostly full sequences launched when idle, a few commands while busy
  task automatic next_word(output logic [CMD_W-1:0] cmd, output logic [POS_W-1:0] pos);
    int unsigned hi;
    hi = board.max_pos + 2;
    if (hi > 127) hi = 127;
    pos = POS_W'($urandom_range(0, 127));
    if (!board.busy() && $urandom_range(0, 9) < 6) begin
      cmd = $urandom_range(0, 1) ? CMD_SET : CMD_STORE;
      if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, hi));
    end else if (board.busy() && $urandom_range(0, 9) == 0) begin
      cmd = $urandom_range(0, 1) ? CMD_SET : CMD_STORE;
    end else begin
      cmd = ($urandom_range(0, 3) == 0) ? CMD_RSVD : CMD_TICK;
    end
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    int unsigned      n_words;
    int unsigned      guard;
    board          = new();
    idling         = 1'b1;
    long_hold_req  = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.cmd      <= CMD_TICK;
    in_if.position <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero clock and half period act as one; tiny pulse counts
    program_regs(8'd0, 8'd0, 8'd0, 20'd1, 7'd1, 7'd3);
    send_word(CMD_TICK, 7'd0);
    send_word(CMD_SET, 7'h7F);
    send_word(CMD_RSVD, 7'h7F);
    send_word(CMD_STORE, 7'd0);
    send_word(CMD_SET, 7'h55);
    repeat (9) send_word(CMD_TICK, 7'h2A);
    send_word(CMD_STORE, 7'd2);
    repeat (11) send_word(CMD_TICK, 7'h55);

    for (int ph = 1; ph <= LAST_PHASE; ph++) begin
      wait_drain();
      case (ph)
        1: program_regs(8'hFF, 8'hFF, 8'hFF, 20'hFFFFF, 7'h7F, 7'h7F);
        2: program_regs(8'd0, 8'd0, 8'd0, 20'd0, 7'd0, 7'd0);
        default: program_regs(CPU_W'($urandom_range(1, 3)), HALF_W'($urandom_range(1, 2)),
                              DSU_W'($urandom_range(0, 3)), US_W'($urandom_range(0, 10)),
                              ZP_W'($urandom_range(0, 8)), MAXP_W'($urandom_range(0, 15)));
      endcase
      n_words = (ph == 1) ? 60 : (ph == 2) ? 600 : 160;
      if (ph == 4) long_hold_req = 1'b1;
      for (int i = 0; i < n_words; i++) begin
        if (i % 40 == 0) idling = (ph != LAST_PHASE) && ($urandom_range(0, 3) != 0);
        if (ph == 5 && i == 80) wait_drain();
        if (idling && $urandom_range(0, 6) == 0) src_gap($urandom_range(1, 14));
        next_word(cmd, pos);
        if (ph == 1 && i == 0 && !board.busy()) begin
          cmd = CMD_STORE;
          pos = 7'h7F;
        end
        send_word(cmd, pos);
      end
    end

    in_if.valid <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (board.n_err == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/udps_pkg.sv
rtl/core/udps_chan_if.sv
rtl/core/udps_timer.sv
rtl/core/udps_fsm.sv
rtl/core/updown_pot_position_sequencer.sv
rtl/core/udps_chk.sv
test/tb_updown_pot_position_sequencer.sv
